// File: rtl/cmif_pkg.sv
// Package for the constant-fold multiplier: request codes and widths.
// No dependencies.
`default_nettype none
package cmif_pkg;
  localparam int DATA_W      = 64;
  localparam int EXP_W       = 32;
  localparam int MANT_BITS_D = 64;
  localparam logic [1:0] REQ_INT   = 2'd0;
  localparam logic [1:0] REQ_FLOAT = 2'd1;
endpackage
`default_nettype wire

// File: rtl/constant_multiply_int_and_float.sv
// Top level of the constant-fold multiplier: integer and soft-float multiply.
// Depends on cmif_pkg.
//
// channel | direction | handshake     | payload
// in      | in        | in_valid/stall| req_type, a_value .. b_exponent
// out     | out       | out_valid/... | ok, product_value .. product_exponent
//
// Four register stages: operand prepare, 32x32 partial products,
// 128-bit sum with leading-zero count, normalise and round.
// One item per cycle while out_stall is low; an accepted item passes stages 1 to 4,
// and out_valid is the stage-4 valid bit.
// rst clears the valid bits only; payload registers carry no reset.
// A stall holds every stage whose successor is full; no item is lost.
`default_nettype none
module constant_multiply_int_and_float
  import cmif_pkg::*;
#(
  parameter int MANT_BITS = MANT_BITS_D
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [1:0]              req_type,
  input  wire logic [DATA_W-1:0]       a_value,
  input  wire logic [DATA_W-1:0]       b_value,
  input  wire logic                    a_signed,
  input  wire logic                    b_signed,
  input  wire logic                    a_overflow,
  input  wire logic                    a_negative,
  input  wire logic                    b_negative,
  input  wire logic signed [EXP_W-1:0] a_exponent,
  input  wire logic signed [EXP_W-1:0] b_exponent,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         ok,
  output logic [DATA_W-1:0]            product_value,
  output logic                         product_signed,
  output logic                         product_overflow,
  output logic                         product_negative,
  output logic signed [EXP_W-1:0]      product_exponent
);
  localparam logic [DATA_W-1:0] MMASK = {DATA_W{1'b1}} >> (DATA_W - MANT_BITS);
  localparam int RK = 127 - MANT_BITS;
  localparam logic [6:0] LZ_BIAS = 7'(128 - 2 * MANT_BITS);

  // pipeline advance: a stage moves when the next one is free
  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4;
  assign adv4 = !v4 || !out_stall;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign in_stall = !adv1;

  // stage 1: decode, take magnitudes, mask mantissas
  logic              s1_int, s1_flt, s1_sg, s1_neg_prod, s1_ovf_in, s1_sign, s1_zero;
  logic [DATA_W-1:0] s1_a, s1_b;
  logic [EXP_W-1:0]  s1_e;
  logic              sg_c, na_c, nb_c, flt_c;
  logic [DATA_W-1:0] ma_c, mb_c;
  always_comb begin
    sg_c  = a_signed | b_signed;
    flt_c = (req_type == REQ_FLOAT);
    na_c  = sg_c && a_value[DATA_W-1];
    nb_c  = sg_c && b_value[DATA_W-1];
    if (flt_c) begin
      ma_c = a_value & MMASK;
      mb_c = b_value & MMASK;
    end else begin
      ma_c = na_c ? (DATA_W'(0) - a_value) : a_value;
      mb_c = nb_c ? (DATA_W'(0) - b_value) : b_value;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv1) v1 <= in_valid;
    if (adv1) begin
      s1_int      <= (req_type == REQ_INT);
      s1_flt      <= flt_c;
      s1_sg       <= sg_c;
      s1_neg_prod <= na_c ^ nb_c;
      s1_ovf_in   <= a_overflow;
      s1_sign     <= a_negative ^ b_negative;
      s1_zero     <= (ma_c == '0) || (mb_c == '0);
      s1_a        <= ma_c;
      s1_b        <= mb_c;
      s1_e        <= EXP_W'(a_exponent) + EXP_W'(b_exponent) + EXP_W'(1);
    end
  end

  // stage 2: four 32x32 partial products
  logic              s2_int, s2_flt, s2_sg, s2_neg_prod, s2_ovf_in, s2_sign, s2_zero;
  logic [DATA_W-1:0] s2_ll, s2_lh, s2_hl, s2_hh;
  logic [EXP_W-1:0]  s2_e;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv2) v2 <= v1;
    if (adv2) begin
      s2_int <= s1_int; s2_flt <= s1_flt; s2_sg <= s1_sg;
      s2_neg_prod <= s1_neg_prod; s2_ovf_in <= s1_ovf_in;
      s2_sign <= s1_sign; s2_zero <= s1_zero; s2_e <= s1_e;
      s2_ll <= s1_a[31:0]  * s1_b[31:0];
      s2_lh <= s1_a[31:0]  * s1_b[63:32];
      s2_hl <= s1_a[63:32] * s1_b[31:0];
      s2_hh <= s1_a[63:32] * s1_b[63:32];
    end
  end

  // stage 3: sum, overflow test, leading-zero count
  logic [127:0] sum_c;
  logic [6:0]   lz_c;
  logic         ovf_c;
  always_comb begin
    sum_c = {64'd0, s2_ll} + {32'd0, s2_lh, 32'd0} + {32'd0, s2_hl, 32'd0}
          + {s2_hh, 64'd0};
    lz_c = 7'd0;
    for (int i = 0; i < 128; i++) begin
      if (sum_c[i]) lz_c = 7'(127 - i);
    end
    if (s2_sg) begin
      if (sum_c[127:64] != '0) ovf_c = 1'b1;
      else if (s2_neg_prod) ovf_c = sum_c[63:0] > 64'h8000_0000_0000_0000;
      else ovf_c = sum_c[63];
    end else begin
      ovf_c = sum_c[127:64] != '0;
    end
  end
  logic              s3_int, s3_flt, s3_sg, s3_neg_prod, s3_ovf, s3_sign, s3_zero;
  logic [127:0]      s3_p;
  logic [6:0]        s3_lz;
  logic [EXP_W-1:0]  s3_e;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv3) v3 <= v2;
    if (adv3) begin
      s3_int <= s2_int; s3_flt <= s2_flt; s3_sg <= s2_sg; s3_neg_prod <= s2_neg_prod;
      s3_ovf <= ovf_c | s2_ovf_in; s3_sign <= s2_sign; s3_zero <= s2_zero;
      s3_p <= sum_c; s3_lz <= lz_c; s3_e <= s2_e;
    end
  end

  // stage 4: normalise, round on the first dropped bit, renormalise on carry
  logic [127:0]      norm_c;
  logic [DATA_W-1:0] mant_c, mant_inc;
  logic [EXP_W-1:0]  e_c;
  always_comb begin
    norm_c   = s3_p << s3_lz;
    mant_c   = 64'(norm_c[127:64] >> (DATA_W - MANT_BITS));
    e_c      = s3_e - EXP_W'(s3_lz - LZ_BIAS);
    mant_inc = (mant_c + 64'd1) & MMASK;
    if (norm_c[RK]) begin
      if (mant_inc == '0) begin
        mant_c = 64'd1 << (MANT_BITS - 1);
        e_c    = e_c + EXP_W'(1);
      end else begin
        mant_c = mant_inc;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv4) v4 <= v3;
    if (adv4) begin
      ok               <= s3_int | s3_flt;
      product_signed   <= s3_int & s3_sg;
      product_overflow <= s3_int & s3_ovf;
      product_negative <= s3_flt & s3_sign;
      if (s3_int) begin
        // low word of the magnitude product, sign restored modulo 2^64
        product_value    <= s3_neg_prod ? (DATA_W'(0) - s3_p[63:0]) : s3_p[63:0];
        product_exponent <= '0;
      end else if (s3_flt && !s3_zero) begin
        product_value    <= mant_c;
        product_exponent <= e_c;
      end else begin
        product_value    <= '0;
        product_exponent <= '0;
      end
    end
  end
  assign out_valid = v4;
endmodule
`default_nettype wire

// File: rtl/cmif_checker.sv
// Port-level checker for the constant-fold multiplier, bound to the top level.
// Depends on cmif_pkg.
`default_nettype none
module cmif_checker
  import cmif_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic              ok,
  input wire logic [DATA_W-1:0] product_value,
  input wire logic              product_signed,
  input wire logic              product_overflow,
  input wire logic              product_negative
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(product_value))
    else $error("stalled item changed");
  a_nok: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> product_value == '0 && !product_signed && !product_overflow)
    else $error("unsupported item carries data");
  a_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(product_negative && (product_signed || product_overflow)))
    else $error("float and integer flags mixed");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");
endmodule
bind constant_multiply_int_and_float cmif_checker u_cmif_checker (.*);
`default_nettype wire
